// ===== src/json_string_unescape_top_assert.svh =====
// assertion macros of the checker of the string unescaper
`ifndef JSON_STRING_UNESCAPE_TOP_ASSERT_SVH
`define JSON_STRING_UNESCAPE_TOP_ASSERT_SVH

// clocked assertion, off while reset is held
`define JSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds while reset is held
`define JSU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/jsu_pkg.sv =====
// shared constants, types and helper functions of the string unescaper
package jsu_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int TOTAL_W     = 16;
    localparam int WIDE_W      = LENGTH_BITS + TOTAL_W;

    // phase codes
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_ESC  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_OPEN  = 2'd1;
    localparam logic [1:0] ST_NO_CLOSE = 2'd2;
    localparam logic [1:0] ST_BAD_ESC  = 2'd3;

    // byte codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_LC_N   = 8'h6e;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;

    typedef struct packed {
        logic [1:0]             phase;
        logic [LENGTH_BITS-1:0] count;
        logic                   bad;
    } state_t;

    typedef struct packed {
        logic               emit;
        logic [7:0]         out_byte;
        logic               char_valid;
        logic               done_res;
        logic [1:0]         status;
        logic [TOTAL_W-1:0] total_length;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] ch;
    } esc_t;

    // decoded character of an escape, ok low when unsupported
    function automatic esc_t map_escape(input logic [7:0] c);
        esc_t e;
        e.ok = 1'b1;
        case (c)
            CH_LC_N:   e.ch = CH_LF;
            CH_LC_T:   e.ch = CH_TAB;
            CH_LC_R:   e.ch = CH_CR;
            CH_LC_B:   e.ch = CH_BS;
            CH_LC_F:   e.ch = CH_FF;
            CH_BSLASH: e.ch = CH_BSLASH;
            CH_SLASH:  e.ch = CH_SLASH;
            CH_QUOTE:  e.ch = CH_QUOTE;
            default:
            begin
                e.ok = 1'b0;
                e.ch = CH_NUL;
            end
        endcase
        return e;
    endfunction

    // count plus one, held at all ones
    function automatic logic [LENGTH_BITS-1:0] count_inc(input logic [LENGTH_BITS-1:0] c);
        logic [LENGTH_BITS-1:0] r;
        r = (&c) ? c : c + LENGTH_BITS'(1);
        return r;
    endfunction

    // byte count squeezed into the result length field
    function automatic logic [TOTAL_W-1:0] count_to_total(input logic [LENGTH_BITS-1:0] c);
        logic [WIDE_W-1:0] wide;
        logic [TOTAL_W-1:0] t;
        wide = WIDE_W'(c);
        if (wide > WIDE_W'({TOTAL_W{1'b1}}))
            t = '1;
        else
            t = wide[TOTAL_W-1:0];
        return t;
    endfunction

endpackage

// ===== src/jsu_decode.sv =====
// per-byte decision logic: next state and result of one raw byte
module jsu_decode
(
    input  logic [7:0]       data_byte,
    input  jsu_pkg::state_t  state_cur,
    output jsu_pkg::state_t  state_next,
    output jsu_pkg::result_t res
);
    import jsu_pkg::*;

    esc_t esc;

    assign esc = map_escape(data_byte);

    always_comb
    begin
        state_next       = state_cur;
        res.emit         = 1'b0;
        res.out_byte     = CH_NUL;
        res.char_valid   = 1'b0;
        res.done_res     = 1'b0;
        res.status       = ST_OK;
        res.total_length = '0;
        case (state_cur.phase)
            PH_BODY:
            begin
                if (data_byte == CH_NUL)
                begin
                    state_next.phase = PH_WAIT;
                    res.emit         = 1'b1;
                    res.done_res     = 1'b1;
                    res.status       = ST_NO_CLOSE;
                    res.total_length = count_to_total(state_cur.count);
                end
                else
                begin
                    state_next.count = count_inc(state_cur.count);
                    if (data_byte == CH_BSLASH)
                        state_next.phase = PH_ESC;
                    else if (data_byte == CH_QUOTE)
                    begin
                        state_next.phase = PH_WAIT;
                        res.emit         = 1'b1;
                        res.done_res     = 1'b1;
                        res.status       = state_cur.bad ? ST_BAD_ESC : ST_OK;
                        res.total_length = count_to_total(state_next.count);
                    end
                    else
                    begin
                        res.emit       = 1'b1;
                        res.char_valid = 1'b1;
                        res.out_byte   = data_byte;
                    end
                end
            end
            PH_ESC:
            begin
                if (data_byte == CH_NUL)
                begin
                    state_next.phase = PH_WAIT;
                    res.emit         = 1'b1;
                    res.done_res     = 1'b1;
                    res.status       = ST_NO_CLOSE;
                    res.total_length = count_to_total(state_cur.count);
                end
                else
                begin
                    state_next.count = count_inc(state_cur.count);
                    state_next.phase = PH_BODY;
                    if (esc.ok)
                    begin
                        res.emit       = 1'b1;
                        res.char_valid = 1'b1;
                        res.out_byte   = esc.ch;
                    end
                    else
                        state_next.bad = 1'b1;
                end
            end
            default:
            begin
                // waiting, the spare phase code acts the same
                if (data_byte == CH_QUOTE)
                begin
                    state_next.phase = PH_BODY;
                    state_next.count = LENGTH_BITS'(1);
                    state_next.bad   = 1'b0;
                end
                else
                begin
                    state_next.phase = PH_WAIT;
                    res.emit         = 1'b1;
                    res.done_res     = 1'b1;
                    res.status       = ST_NO_OPEN;
                end
            end
        endcase
    end

endmodule

// ===== src/json_string_unescape_top.sv =====
// top level of the json string unescaper: input register, decode, result register
// One raw byte per beat goes in on in_valid/in_ready and at most one result beat
// comes out on out_valid/out_ready. The block sustains one byte per clock while
// the consumer takes its results: a byte sits in the input register, the decode
// logic works out the next parse state and the result from that byte and the
// parse state, and the result lands in the result register when the byte moves
// on. Bytes that yield nothing (the opening quote, a backslash, an unsupported
// escape) still take their slot. in_ready drops only while the result register
// holds a beat the consumer has not taken and the input register is full.
// A result carries either a decoded character (char_valid) or the end of a string
// (done_res) with its status and its length, counting the quotes read; on an
// error status the consumer throws away the characters already delivered.
module json_string_unescape_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  data_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        char_valid,
    output logic                        done_res,
    output logic [1:0]                  status,
    output logic [jsu_pkg::TOTAL_W-1:0] total_length
);
    import jsu_pkg::*;

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;

    // parse state
    state_t state_reg;
    state_t state_next;

    // result register
    logic    out_vld_reg;
    result_t res_reg;
    result_t res_next;

    logic advance;

    jsu_decode u_decode
    (
        .data_byte  (in_byte_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // held byte moves on once the result register is free or being drained
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            state_reg.phase <= PH_WAIT;
            state_reg.count <= '0;
            state_reg.bad   <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (advance)
            begin
                state_reg   <= state_next;
                out_vld_reg <= res_next.emit;
            end
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_byte_reg <= data_byte;
        if (advance && res_next.emit)
            res_reg <= res_next;
    end

    assign out_valid    = out_vld_reg;
    assign out_byte     = res_reg.out_byte;
    assign char_valid   = res_reg.char_valid;
    assign done_res     = res_reg.done_res;
    assign status       = res_reg.status;
    assign total_length = res_reg.total_length;

endmodule

// ===== src/jsu_checker.sv =====
// port-level checker of the string unescaper and its bind
`include "json_string_unescape_top_assert.svh"

module jsu_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [7:0]                  data_byte,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [7:0]                  out_byte,
    input logic                        char_valid,
    input logic                        done_res,
    input logic [1:0]                  status,
    input logic [jsu_pkg::TOTAL_W-1:0] total_length
);
    import jsu_pkg::*;

    logic                in_stall;
    logic                out_stall;
    logic                no_open_end;
    logic                ok_end;
    logic [TOTAL_W+11:0] res_bits;

    assign in_stall    = in_valid && !in_ready;
    assign out_stall   = out_valid && !out_ready;
    assign no_open_end = out_valid && done_res && status == ST_NO_OPEN;
    assign ok_end      = out_valid && done_res && status == ST_OK;
    assign res_bits    = {out_byte, char_valid, done_res, status, total_length};

    // a waiting byte beat holds
    `JSU_ASSERT(a_in_hold, in_stall |=> in_valid && $stable(data_byte), "input beat not held")

    // a stalled result beat holds
    `JSU_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(res_bits), "result beat not held")

    // input side stalls only behind an untaken result
    `JSU_ASSERT(a_ready_stall, !in_ready |-> out_stall, "input stalled without output backpressure")

    // a missing opening quote reports nothing consumed
    `JSU_ASSERT(a_no_open_len, no_open_end |-> total_length == '0 && !char_valid, "bad no-open beat")

    // a clean string counts at least its two quotes
    `JSU_ASSERT(a_ok_len, ok_end |-> total_length >= TOTAL_W'(2) && !char_valid, "short ok result")

endmodule

bind json_string_unescape_top jsu_checker u_jsu_checker (.*);

// ===== verif/tb_json_string_unescape_top.sv =====
// testbench of the json string unescaper: byte driver, result monitor and a local decoder
module tb_json_string_unescape_top;

    import jsu_pkg::*;

    // one decoded result beat as the block should produce it
    typedef struct packed {
        logic [7:0]         ch;
        logic               is_char;
        logic               is_end;
        logic [1:0]         code;
        logic [TOTAL_W-1:0] len;
    } decoded_t;

    // one raw byte waiting to be sent, with its pacing marks
    typedef struct {
        logic [7:0] data;
        bit         hold;   // wait for every outstanding result before sending
        bit         quiet;  // no idling on either side while this beat is in flight
    } raw_beat_t;

    localparam logic [7:0] ESC_LETTERS [8] = '{CH_LC_N, CH_LC_T, CH_LC_R, CH_LC_B,
                                               CH_LC_F, CH_BSLASH, CH_SLASH, CH_QUOTE};
    localparam int RANDOM_BYTES = 1250;
    localparam int LONG_BODY    = 100;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [7:0]          data_byte  = 8'h00;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [7:0]          out_byte;
    logic                char_valid;
    logic                done_res;
    logic [1:0]          status;
    logic [TOTAL_W-1:0]  total_length;

    // stimulus and expectations
    raw_beat_t raw_bytes [$];
    decoded_t  pending_results [$];
    bit        next_hold;
    bit        fill_quiet;

    // local copy of the parse state
    logic [1:0]             dec_phase = PH_WAIT;
    logic [LENGTH_BITS-1:0] dec_count = '0;
    logic                   dec_bad   = 1'b0;

    // pacing and bookkeeping
    int  gap_left      = 0;
    int  stall_left    = 0;
    bit  quiet_now     = 1'b0;
    int  results_pushed = 0;
    int  results_taken  = 0;
    int  bytes_taken   = 0;
    int  err_count     = 0;
    int  chars_taken   = 0;
    int  ends_taken [4] = '{0, 0, 0, 0};
    int  longest_len   = 0;

    json_string_unescape_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .char_valid   (char_valid),
        .done_res     (done_res),
        .status       (status),
        .total_length (total_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // idle length: mostly none, often short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // byte count as reported, clipped to the result field
    function automatic logic [TOTAL_W-1:0] clip_len(input logic [LENGTH_BITS-1:0] c);
        if (longint'(c) > longint'({TOTAL_W{1'b1}}))
            return '1;
        return TOTAL_W'(c);
    endfunction

    function automatic void push_end(input logic [1:0] code, input logic [TOTAL_W-1:0] len);
        decoded_t r;
        r = '0;
        r.is_end = 1'b1;
        r.code = code;
        r.len = len;
        pending_results.push_back(r);
        results_pushed++;
    endfunction

    function automatic void push_char(input logic [7:0] ch);
        decoded_t r;
        r = '0;
        r.is_char = 1'b1;
        r.ch = ch;
        pending_results.push_back(r);
        results_pushed++;
    endfunction

    // decode one accepted raw byte into the expected result beats
    function automatic void unescape_byte(input logic [7:0] b);
        logic [7:0] ch;
        bit         known;
        case (dec_phase)
            PH_BODY:
            begin
                if (b == CH_NUL)
                begin
                    dec_phase = PH_WAIT;
                    push_end(ST_NO_CLOSE, clip_len(dec_count));
                end
                else
                begin
                    if (dec_count != '1)
                        dec_count++;
                    if (b == CH_BSLASH)
                        dec_phase = PH_ESC;
                    else if (b == CH_QUOTE)
                    begin
                        dec_phase = PH_WAIT;
                        push_end(dec_bad ? ST_BAD_ESC : ST_OK, clip_len(dec_count));
                    end
                    else
                        push_char(b);
                end
            end
            PH_ESC:
            begin
                if (b == CH_NUL)
                begin
                    // missing close wins over a bad escape
                    dec_phase = PH_WAIT;
                    push_end(ST_NO_CLOSE, clip_len(dec_count));
                end
                else
                begin
                    if (dec_count != '1)
                        dec_count++;
                    dec_phase = PH_BODY;
                    known = 1'b1;
                    case (b)
                        CH_LC_N:   ch = CH_LF;
                        CH_LC_T:   ch = CH_TAB;
                        CH_LC_R:   ch = CH_CR;
                        CH_LC_B:   ch = CH_BS;
                        CH_LC_F:   ch = CH_FF;
                        CH_BSLASH: ch = CH_BSLASH;
                        CH_SLASH:  ch = CH_SLASH;
                        CH_QUOTE:  ch = CH_QUOTE;
                        default:
                        begin
                            known = 1'b0;
                            ch = CH_NUL;
                        end
                    endcase
                    if (known)
                        push_char(ch);
                    else
                        dec_bad = 1'b1;
                end
            end
            default:
            begin
                if (b == CH_QUOTE)
                begin
                    dec_phase = PH_BODY;
                    dec_count = LENGTH_BITS'(1);
                    dec_bad = 1'b0;
                end
                else
                begin
                    dec_phase = PH_WAIT;
                    push_end(ST_NO_OPEN, '0);
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            err_count++;
        end
    endfunction

    // driver: presents queued bytes, predicts each accepted beat
    always @(posedge clk or negedge rst_n)
    begin : byte_driver
        bit        fire;
        int        gap_n;
        raw_beat_t item;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= 8'h00;
            gap_left  <= 0;
            quiet_now <= 1'b0;
        end
        else
        begin
            fire = in_valid && in_ready;
            gap_n = gap_left;
            if (fire)
            begin
                unescape_byte(data_byte);
                bytes_taken++;
                if (!quiet_now)
                    gap_n = pick_idle();
            end
            if (in_valid && !fire)
            begin
                // beat still waiting, payload held
            end
            else if (gap_n > 0)
            begin
                gap_n--;
                in_valid <= 1'b0;
            end
            else if (raw_bytes.size() > 0 &&
                     (!raw_bytes[0].hold || results_taken >= results_pushed))
            begin
                item = raw_bytes.pop_front();
                in_valid  <= 1'b1;
                data_byte <= item.data;
                quiet_now <= item.quiet;
            end
            else
                in_valid <= 1'b0;
            gap_left <= gap_n;
        end
    end

    // monitor: takes result beats with random back-pressure and checks them
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        decoded_t w;
        int       stall_n;
        if (!rst_n)
        begin
            out_ready     <= 1'b0;
            stall_left    <= 0;
            results_taken <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual byte %0h char %0b",
                             $time, out_byte, char_valid);
                    $display("%0t:   actual done %0b status %0d length %0d",
                             $time, done_res, status, total_length);
                    err_count++;
                end
                else
                begin
                    w = pending_results.pop_front();
                    check_field("out_byte", 32'(w.ch), 32'(out_byte));
                    check_field("char_valid", 32'(w.is_char), 32'(char_valid));
                    check_field("done_res", 32'(w.is_end), 32'(done_res));
                    check_field("status", 32'(w.code), 32'(status));
                    check_field("total_length", 32'(w.len), 32'(total_length));
                end
                if (char_valid)
                    chars_taken++;
                if (done_res)
                begin
                    ends_taken[status]++;
                    if (int'(total_length) > longest_len)
                        longest_len = int'(total_length);
                end
                results_taken <= results_taken + 1;
            end
            stall_n = stall_left;
            if (quiet_now)
            begin
                stall_n = 0;
                out_ready <= 1'b1;
            end
            else if (stall_n > 0)
            begin
                stall_n--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_n = pick_idle();
            end
            stall_left <= stall_n;
        end
    end

    function automatic void push_raw(input logic [7:0] b);
        raw_beat_t item;
        item.data = b;
        item.hold = next_hold;
        item.quiet = fill_quiet;
        next_hold = 1'b0;
        raw_bytes.push_back(item);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    // one element of a string body: plain byte, known escape or bad escape
    function automatic int push_body_element();
        int         r;
        logic [7:0] b;
        bit         hit;
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            push_raw(plain_byte());
            return 1;
        end
        push_raw(CH_BSLASH);
        if (r < 95)
            push_raw(ESC_LETTERS[$urandom_range(0, 7)]);
        else
        begin
            do
            begin
                b = 8'($urandom_range(1, 255));
                hit = 1'b0;
                foreach (ESC_LETTERS[k])
                    if (ESC_LETTERS[k] == b)
                        hit = 1'b1;
            end
            while (hit);
            push_raw(b);
        end
        return 2;
    endfunction

    initial
    begin : stimulus
        int         n;
        int         r;
        int         random_items;

        next_hold = 1'b0;
        fill_quiet = 1'b0;

        // zero byte while waiting: no opening quote
        push_raw(CH_NUL);
        // every known escape and the top byte inside a closed string
        push_raw(CH_QUOTE);
        push_raw(8'hff);
        foreach (ESC_LETTERS[k])
        begin
            push_raw(CH_BSLASH);
            push_raw(ESC_LETTERS[k]);
        end
        push_raw(CH_QUOTE);
        // bad escape, then the buffer ends right after a backslash
        push_raw(CH_QUOTE);
        push_raw(CH_BSLASH);
        push_raw(8'h78);
        push_raw(CH_BSLASH);
        push_raw(CH_NUL);

        // one longer string sent with no idling
        next_hold = 1'b1;
        fill_quiet = 1'b1;
        push_raw(CH_QUOTE);
        for (int i = 0; i < LONG_BODY; i++)
            void'(push_body_element());
        push_raw(CH_QUOTE);
        fill_quiet = 1'b0;

        // random part: mostly well-formed strings, some noise and broken ends
        random_items = 0;
        next_hold = 1'b1;
        while (random_items < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 49) == 0)
                next_hold = 1'b1;
            fill_quiet = ($urandom_range(0, 99) < 8);
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                push_raw(CH_QUOTE);
                random_items++;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
                for (int i = 0; i < n; i++)
                    random_items += push_body_element();
                r = $urandom_range(0, 99);
                if (r < 85)
                    push_raw(CH_QUOTE);
                else if (r < 95)
                    push_raw(CH_NUL);
                else
                begin
                    push_raw(CH_BSLASH);
                    push_raw(CH_NUL);
                    random_items++;
                end
                random_items++;
            end
            else if (r < 85)
            begin
                push_raw(8'($urandom_range(0, 255)));
                random_items++;
            end
            else
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    push_raw(8'($urandom_range(0, 255)));
                random_items += n;
            end
        end
        fill_quiet = 1'b0;

        wait (rst_n);
        wait (raw_bytes.size() == 0 && !in_valid);
        wait (results_taken >= results_pushed);
        repeat (10) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected result beats never arrived", $time,
                     pending_results.size());
            err_count++;
        end

        $display("run covered %0d raw bytes, %0d decoded characters, longest length %0d",
                 bytes_taken, chars_taken, longest_len);
        $display("string ends: ok %0d, no opening quote %0d, no closing quote %0d, bad escape %0d",
                 ends_taken[ST_OK], ends_taken[ST_NO_OPEN], ends_taken[ST_NO_CLOSE],
                 ends_taken[ST_BAD_ESC]);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // guard against a hung handshake
    initial
    begin
        #10000000;
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
